@@ src/ncm_pkg.sv @@
// Package for the normalization cube map texel generator.
// Types, pipeline depths and fixed-point constants shared by all modules.
`timescale 1ns / 1ps
package ncm_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = 13;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd256;

    // Q2.16 unit value
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    // divider: quotient of a*2^17/d with a <= d, one quotient bit a stage
    localparam int DIV_W      = 17;
    localparam int DIV_FRAC   = 17;
    localparam int DIV_STAGES = DIV_FRAC + 1;
    localparam int QUO_W      = DIV_FRAC + 1;

    // integer square root of the Q2.32 squared length
    localparam int SQ_IN_W   = 34;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_STAGES = SQ_OUT_W;
    localparam int SQ_REM_W  = SQ_OUT_W + 3;

    localparam int MAG_W = 17;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef struct packed {
        logic       valid;
        logic       err;
        logic [2:0] face;
    } t_side_coord;

    typedef struct packed {
        logic                       valid;
        logic                       err;
        logic [2:0][MAG_W-1:0]      mag;
        logic [2:0]                 neg;
    } t_side_len;

    typedef struct packed {
        logic       valid;
        logic       err;
        logic       zero;
        logic [2:0] neg;
    } t_side_norm;

    typedef struct packed {
        logic       coord_error;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_result;

endpackage

@@ src/normalization_cube_map_texel.sv @@
// Normalization cube map texel generator: one texel per clock while the output
// queue has room. The depth is set by two 18-stage dividers (coordinate mapping,
// then normalization) and a 17-stage square root, one bit per stage. A coordinate
// at or beyond face_size gives zero channels and coord_error; faces 6 and 7 give
// 127,127,127. The user must write face_size only while no texel is in flight;
// the block does not enforce this.
// Depends on ncm_pkg, ncm_div, ncm_sqrt and ncm_outq.
`timescale 1ns / 1ps
module normalization_cube_map_texel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,     // face_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // face[2:0], column[14:3], row[26:15], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tuser     // coord_error
);
    import ncm_pkg::*;

    logic [SIZE_BITS-1:0] r_face_size;
    logic                 ce;
    logic                 q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_face_size <= i_cfg_wdata;
        end
    end

    // whole pipeline advances while the output queue has room
    assign ce            = !q_full;
    assign s_axis_tready = ce;

    // ---- stage 0: input register
    logic                  r0_valid;
    logic [2:0]            r0_face;
    logic [COORD_BITS-1:0] r0_col;
    logic [COORD_BITS-1:0] r0_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (ce) begin
            r0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_face <= s_axis_tdata[2:0];
            r0_col  <= s_axis_tdata[14:3];
            r0_row  <= s_axis_tdata[26:15];
        end
    end

    logic                 s0_err;
    logic [SIZE_BITS-1:0] s0_span;
    logic [DIV_W-1:0]     cdiv_den;
    logic [DIV_W-1:0]     wdiv_num;
    logic [DIV_W-1:0]     hdiv_num;
    t_side_coord          s0_side;

    assign s0_err  = ({1'b0, r0_col} >= r_face_size) || ({1'b0, r0_row} >= r_face_size);
    assign s0_span = (r_face_size < SIZE_BITS'(2)) ? SIZE_BITS'(1)
                                                   : SIZE_BITS'(r_face_size - 1'b1);
    assign cdiv_den = s0_err ? DIV_W'(1) : DIV_W'(s0_span);
    assign wdiv_num = s0_err ? '0 : DIV_W'(r0_col);
    assign hdiv_num = s0_err ? '0 : DIV_W'(r0_row);
    assign s0_side  = '{valid: r0_valid, err: s0_err, face: r0_face};

    logic [QUO_W-1:0] w_quo;
    logic [QUO_W-1:0] h_quo;

    ncm_div u_div_w (.i_clk(i_clk), .i_ce(ce), .i_num(wdiv_num), .i_den(cdiv_den),
                     .o_quo(w_quo));
    ncm_div u_div_h (.i_clk(i_clk), .i_ce(ce), .i_num(hdiv_num), .i_den(cdiv_den),
                     .o_quo(h_quo));

    t_side_coord r_d1 [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) r_d1[i] <= '0;
        end else if (ce) begin
            r_d1[0] <= s0_side;
            for (int i = 1; i < DIV_STAGES; i++) r_d1[i] <= r_d1[i-1];
        end
    end

    // ---- stage 1: w, h and the face swizzle as magnitude and sign
    logic             w_neg, h_neg;
    logic [MAG_W-1:0] w_mag, h_mag;
    logic [2:0][MAG_W-1:0] n1_mag;
    logic [2:0]            n1_neg;
    t_side_coord           s1_in;

    assign s1_in = r_d1[DIV_STAGES-1];
    assign w_neg = (w_quo < ONE_Q16);
    assign h_neg = (h_quo < ONE_Q16);
    assign w_mag = w_neg ? MAG_W'(ONE_Q16 - w_quo) : MAG_W'(w_quo - ONE_Q16);
    assign h_mag = h_neg ? MAG_W'(ONE_Q16 - h_quo) : MAG_W'(h_quo - ONE_Q16);

    always_comb begin
        n1_mag = '0;
        n1_neg = '0;
        unique case (s1_in.face)
            FACE_POS_X: begin
                n1_mag = {w_mag, h_mag, MAG_W'(ONE_Q16)};
                n1_neg = {~w_neg, ~h_neg, 1'b0};
            end
            FACE_NEG_X: begin
                n1_mag = {w_mag, h_mag, MAG_W'(ONE_Q16)};
                n1_neg = {w_neg, ~h_neg, 1'b1};
            end
            FACE_POS_Y: begin
                n1_mag = {h_mag, MAG_W'(ONE_Q16), w_mag};
                n1_neg = {h_neg, 1'b0, w_neg};
            end
            FACE_NEG_Y: begin
                n1_mag = {h_mag, MAG_W'(ONE_Q16), w_mag};
                n1_neg = {~h_neg, 1'b1, w_neg};
            end
            FACE_POS_Z: begin
                n1_mag = {MAG_W'(ONE_Q16), h_mag, w_mag};
                n1_neg = {1'b0, ~h_neg, w_neg};
            end
            FACE_NEG_Z: begin
                n1_mag = {MAG_W'(ONE_Q16), h_mag, w_mag};
                n1_neg = {1'b1, ~h_neg, ~w_neg};
            end
            default: begin
                n1_mag = '0;
                n1_neg = '0;
            end
        endcase
    end

    t_side_len r1_side, r2_side, r3_side;
    logic [2:0][SQ_IN_W-1:0] r2_sq;
    logic [SQ_IN_W-1:0]      r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r2_side.valid <= 1'b0;
            r3_side.valid <= 1'b0;
        end else if (ce) begin
            r1_side.valid <= s1_in.valid;
            r2_side.valid <= r1_side.valid;
            r3_side.valid <= r2_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_side.err <= s1_in.err;
            r1_side.mag <= n1_mag;
            r1_side.neg <= n1_neg;
            // stage 2: squares
            r2_side.err <= r1_side.err;
            r2_side.mag <= r1_side.mag;
            r2_side.neg <= r1_side.neg;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= SQ_IN_W'(r1_side.mag[i]) * SQ_IN_W'(r1_side.mag[i]);
            end
            // stage 3: squared length
            r3_side.err <= r2_side.err;
            r3_side.mag <= r2_side.mag;
            r3_side.neg <= r2_side.neg;
            r3_sum      <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        end
    end

    logic [SQ_OUT_W-1:0] len;

    ncm_sqrt u_sqrt (.i_clk(i_clk), .i_ce(ce), .i_val(r3_sum), .o_root(len));

    t_side_len r_d2 [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQ_STAGES; i++) r_d2[i] <= '0;
        end else if (ce) begin
            r_d2[0] <= r3_side;
            for (int i = 1; i < SQ_STAGES; i++) r_d2[i] <= r_d2[i-1];
        end
    end

    // ---- normalization: each magnitude over the length
    t_side_len        s4_in;
    logic             len_zero;
    logic [DIV_W-1:0] ndiv_den;
    t_side_norm       s4_side;
    logic [2:0][QUO_W-1:0] n_quo;

    assign s4_in    = r_d2[SQ_STAGES-1];
    assign len_zero = (len == '0);
    assign ndiv_den = len_zero ? DIV_W'(1) : DIV_W'(len);
    assign s4_side  = '{valid: s4_in.valid, err: s4_in.err, zero: len_zero, neg: s4_in.neg};

    for (genvar c = 0; c < 3; c++) begin : g_norm
        logic [DIV_W-1:0] num;
        assign num = len_zero ? '0 : DIV_W'(s4_in.mag[c]);
        ncm_div u_div_n (.i_clk(i_clk), .i_ce(ce), .i_num(num), .i_den(ndiv_den),
                         .o_quo(n_quo[c]));
    end

    t_side_norm r_d3 [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) r_d3[i] <= '0;
        end else if (ce) begin
            r_d3[0] <= s4_side;
            for (int i = 1; i < DIV_STAGES; i++) r_d3[i] <= r_d3[i-1];
        end
    end

    // ---- stage 5: channel = floor((n + 1) * 127) in Q16
    t_side_norm      s5_in;
    logic [2:0][7:0] n5_chan;
    t_result         n5_res;
    t_result         r5_res;
    logic            r5_valid;

    assign s5_in = r_d3[DIV_STAGES-1];

    always_comb begin
        logic [MAG_W-1:0] nm;
        logic [17:0]      biased;
        logic [24:0]      prod;
        for (int c = 0; c < 3; c++) begin
            nm     = n_quo[c][QUO_W-1:1];
            biased = s5_in.neg[c] ? 18'(ONE_Q16 - nm) : 18'(ONE_Q16 + nm);
            prod   = {biased, 7'd0} - 25'(biased);
            n5_chan[c] = s5_in.err  ? 8'd0 :
                         s5_in.zero ? 8'd127 : prod[23:16];
        end
        n5_res = '{coord_error: s5_in.err, blue: n5_chan[2], green: n5_chan[1],
                   red: n5_chan[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (ce) begin
            r5_valid <= s5_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_res <= n5_res;
        end
    end

    t_result q_data;

    ncm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r5_valid && ce),
        .i_data  (r5_res),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {q_data.blue, q_data.green, q_data.red};
    assign m_axis_tuser = q_data.coord_error;

    // an error texel carries zero channels
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("error texel with nonzero channels");

    // every channel stays within 0..254
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] != 8'hFF && m_axis_tdata[15:8] != 8'hFF &&
                          m_axis_tdata[23:16] != 8'hFF)
        else $error("channel out of range");

    // a stalled pipeline holds its last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r5_valid) && (!r5_valid || $stable(r5_res)))
        else $error("last stage changed during stall");

    // the fixed unit component always dominates, so a valid face never has zero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s4_in.valid && len_zero |-> s4_in.mag == '0)
        else $error("zero length with nonzero vector");

endmodule

@@ src/ncm_div.sv @@
// Pipelined restoring divider: floor(num * 2^17 / den) for num <= den.
// One quotient bit per stage; depends on ncm_pkg.
`timescale 1ns / 1ps
module ncm_div (
    input  logic                         i_clk,
    input  logic                         i_ce,
    input  logic [ncm_pkg::DIV_W-1:0]    i_num,
    input  logic [ncm_pkg::DIV_W-1:0]    i_den,
    output logic [ncm_pkg::QUO_W-1:0]    o_quo
);
    import ncm_pkg::*;

    logic [DIV_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_W-1:0] r_den [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    // integer bit: set only when num equals den
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= (i_num >= i_den) ? DIV_W'(i_num - i_den) : i_num;
            r_quo[0] <= {{(QUO_W-1){1'b0}}, (i_num >= i_den)};
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_W:0] t;
        logic           ge;
        assign t  = {r_rem[k-1], 1'b0};
        assign ge = (t >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= ge ? DIV_W'(t - {1'b0, r_den[k-1]}) : DIV_W'(t);
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], ge};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

@@ src/ncm_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on ncm_pkg.
`timescale 1ns / 1ps
module ncm_sqrt (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [ncm_pkg::SQ_IN_W-1:0]   i_val,
    output logic [ncm_pkg::SQ_OUT_W-1:0]  o_root
);
    import ncm_pkg::*;

    logic [SQ_IN_W-1:0]  r_val  [SQ_STAGES];
    logic [SQ_REM_W-1:0] r_rem  [SQ_STAGES];
    logic [SQ_OUT_W-1:0] r_root [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [SQ_IN_W-1:0]  val_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_OUT_W-1:0] root_in;
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] trial;
        logic                ge;
        if (k == 0) begin : g_first
            assign val_in  = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign val_in  = r_val[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        // bring down the next two bits of the radicand
        assign t     = {rem_in, val_in[SQ_IN_W-1 -: 2]};
        assign trial = (SQ_REM_W+2)'({root_in, 2'b01});
        assign ge    = (t >= trial);
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_val[k]  <= {val_in[SQ_IN_W-3:0], 2'b00};
                r_rem[k]  <= ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
                r_root[k] <= {root_in[SQ_OUT_W-2:0], ge};
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

@@ src/ncm_outq.sv @@
// Two-entry output queue; lets the pipeline keep moving while one result waits.
// Depends on ncm_pkg for the result type.
`timescale 1ns / 1ps
module ncm_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ncm_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output ncm_pkg::t_result o_data,
    input  logic             i_ready
);
    import ncm_pkg::*;

    t_result     r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop)    r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule
